### rtl/mpsu_pkg.sv
// shared types, constants and fixed-point helpers for the powell source update unit
// no dependencies; used by mpsu_divider and mhd_powell_source_update_unit
`default_nettype none

package mpsu_pkg;

  // quotient bits kept by the velocity divider (result below 2^31 when not saturated)
  localparam int QUO_W   = 31;
  // divider stages: one setup stage plus one stage per quotient bit
  localparam int DIV_STG = QUO_W + 1;

  // configuration register indexes
  localparam logic [1:0] REG_TIME_STEP   = 2'd0;
  localparam logic [1:0] REG_MIN_DENSITY = 2'd1;

  localparam logic [30:0] TIME_STEP_RST   = 31'd66;
  localparam logic [30:0] MIN_DENSITY_RST = 31'd1;

  localparam logic signed [49:0] SAT_HI = 50'sd2147483647;
  localparam logic signed [49:0] SAT_LO = -50'sd2147483648;

  typedef struct packed {
    logic [31:0] rho;
    logic [31:0] mom_x;
    logic [31:0] mom_y;
    logic [31:0] mom_z;
    logic [31:0] field_x;
    logic [31:0] field_y;
    logic [31:0] field_z;
    logic [31:0] energy;
    logic [31:0] div_b;
  } cell_t;

  typedef struct packed {
    logic [31:0] new_mom_x;
    logic [31:0] new_mom_y;
    logic [31:0] new_mom_z;
    logic [31:0] new_field_x;
    logic [31:0] new_field_y;
    logic [31:0] new_field_z;
    logic [31:0] new_energy;
    logic        density_error;
  } result_t;

  // cell data that rides alongside the divider
  typedef struct packed {
    logic             rej;
    logic [2:0][31:0] mom;
    logic [2:0][31:0] fld;
    logic [31:0]      energy;
    logic [31:0]      s;
  } side_t;

  // saturate a wide signed value to signed 32 bits
  function automatic logic [31:0] sat32(input logic signed [49:0] v);
    logic [31:0] r;
    if (v > SAT_HI) begin
      r = 32'h7fff_ffff;
    end else if (v < SAT_LO) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // q16.16 product scaled down, truncated toward zero
  function automatic logic signed [47:0] trunc_q16(input logic signed [63:0] p);
    logic signed [63:0] adj;
    adj = p + (p[63] ? 64'sd65535 : 64'sd0);
    return $signed(adj[63:16]);
  endfunction

endpackage

`default_nettype wire

### rtl/mpsu_divider.sv
// pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage
// depends on mpsu_pkg (QUO_W, DIV_STG, side_t)
`default_nettype none

module mpsu_divider import mpsu_pkg::*; (
  input  logic                   clk,
  input  logic [DIV_STG-1:0]     en,
  input  logic [2:0][31:0]       num,
  input  logic [30:0]            den,
  input  side_t                  side_in,
  output logic [2:0][QUO_W-1:0]  quo,
  output logic [2:0]             ovf,
  output side_t                  side_out
);

  logic [DIV_STG-1:0][2:0][31:0]      rem;
  logic [DIV_STG-1:0][2:0][QUO_W-1:0] qn;
  logic [DIV_STG-1:0][2:0]            ovf_r;
  logic [DIV_STG-1:0][30:0]           den_r;
  side_t                              side_r [DIV_STG];

  // setup: top bits seed the remainder, overflow when |num|*2^16 >= den*2^31
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < 3; k++) begin
        rem[0][k]   <= {15'd0, num[k][31:15]};
        qn[0][k]    <= {num[k][14:0], 16'd0};
        ovf_r[0][k] <= {15'd0, num[k][31:15]} >= {1'b0, den};
      end
      den_r[0]  <= den;
      side_r[0] <= side_in;
    end
  end

  for (genvar j = 1; j < DIV_STG; j++) begin : g_stage
    logic [2:0][31:0] trial;
    logic [2:0][32:0] diff;
    logic [2:0]       ge;

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        trial[k] = {rem[j-1][k][30:0], qn[j-1][k][QUO_W-1]};
        diff[k]  = {1'b0, trial[k]} - {2'b00, den_r[j-1]};
        ge[k]    = !diff[k][32];
      end
    end

    // qn shifts out dividend bits at the top and takes quotient bits at the bottom
    always_ff @(posedge clk) begin
      if (en[j]) begin
        for (int k = 0; k < 3; k++) begin
          rem[j][k] <= ge[k] ? diff[k][31:0] : trial[k];
          qn[j][k]  <= {qn[j-1][k][QUO_W-2:0], ge[k]};
        end
        ovf_r[j]  <= ovf_r[j-1];
        den_r[j]  <= den_r[j-1];
        side_r[j] <= side_r[j-1];
      end
    end
  end

  assign quo      = qn[DIV_STG-1];
  assign ovf      = ovf_r[DIV_STG-1];
  assign side_out = side_r[DIV_STG-1];

endmodule

`default_nettype wire

### rtl/mhd_powell_source_update_unit.sv
// top level of the powell eight-wave source update: config registers, pipeline control
// and datapath; depends on mpsu_pkg and mpsu_divider
`default_nettype none

// Takes one MHD cell per request (density, momenta, field, energy, divergence) and returns
// one result with momentum, field and energy advanced by the Powell source term, all in
// signed Q16.16 with truncating products and saturating sums. A cell whose density is at or
// below min_density passes through unchanged with density_error set. The unit is a 41-stage
// pipeline and accepts one cell every cycle, except while every stage holds a cell and the
// output side is not taking results, which drops cell_ready. Most of that depth is the
// velocity divider, three restoring-division lanes that retire one quotient bit per stage
// (32 stages including setup), followed by two rounds of 32x32 multiply, truncate and
// saturating add. Every stage has its own valid bit and moves whenever the stage after it
// is empty or moving, so a stalled output fills bubbles before cell_ready drops, and
// nothing is lost or repeated. Registers time_step (index 0) and min_density (index 1) are
// written through cfg_we/cfg_index/cfg_data and should only change while the pipeline is
// empty; writes to other indexes are ignored.
module mhd_powell_source_update_unit import mpsu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cell_valid,
  output logic        cell_ready,
  input  cell_t       cell_data,
  output logic        result_valid,
  input  logic        result_ready,
  output result_t     result,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  // stage numbering
  localparam int S_IN   = 0;                // latch cell, dt*divb product, density check
  localparam int S_PREP = 1;                // source factor s, momentum magnitudes
  localparam int S_DIV0 = 2;                // first divider stage
  localparam int S_VEL  = S_DIV0 + DIV_STG; // signed, saturated velocity
  localparam int S_MUL  = S_VEL + 1;        // nine products
  localparam int S_TRN  = S_MUL + 1;        // truncate products
  localparam int S_SUM  = S_TRN + 1;        // momentum, field updates and u.B
  localparam int S_EMUL = S_SUM + 1;        // s * u.B
  localparam int S_ETRN = S_EMUL + 1;       // truncate energy product
  localparam int S_OUT  = S_ETRN + 1;       // energy update, result register
  localparam int NSTG   = S_OUT + 1;

  // configuration registers
  logic [30:0] time_step;
  logic [30:0] min_density;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step   <= TIME_STEP_RST;
      min_density <= MIN_DENSITY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TIME_STEP:   time_step   <= cfg_data;
        REG_MIN_DENSITY: min_density <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline control: a stage loads when it is empty or the next one loads
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] vld_next;
  logic [NSTG:0]   en;

  assign en[NSTG] = result_ready;
  for (genvar i = 0; i < NSTG; i++) begin : g_en
    assign en[i] = !vld[i] || en[i+1];
  end

  always_comb begin
    vld_next[0] = en[0] ? cell_valid : vld[0];
    for (int i = 1; i < NSTG; i++) begin
      vld_next[i] = en[i] ? vld[i-1] : vld[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign cell_ready   = en[S_IN];
  assign result_valid = vld[S_OUT];

  // ---------------------------------------------------------------------------------------
  // stage in: latch the request, start dt*divB, compare density (signed rho vs unsigned min)
  cell_t              in_cell;
  logic               in_rej;
  logic signed [63:0] in_prod;

  always_ff @(posedge clk) begin
    if (en[S_IN]) begin
      in_cell <= cell_data;
      in_rej  <= $signed({cell_data.rho[31], cell_data.rho}) <= $signed({2'b00, min_density});
      in_prod <= $signed({1'b0, time_step}) * $signed(cell_data.div_b);
    end
  end

  // ---------------------------------------------------------------------------------------
  // stage prep: s = -trunc(dt*divB / 2^16) saturated, written as ~floor + (negative and inexact ? 0 : 1)
  logic [47:0]      prep_floor;
  logic             prep_corr;
  logic [47:0]      prep_neg;
  logic [2:0][31:0] prep_mom;
  logic [2:0][31:0] prep_abs_c;

  side_t            prep_side;
  logic [2:0][31:0] prep_abs;
  logic [30:0]      prep_den;

  always_comb begin
    prep_floor = in_prod[63:16];
    prep_corr  = in_prod[63] && (in_prod[15:0] != 16'd0);
    prep_neg   = ~prep_floor + {47'd0, !prep_corr};
    prep_mom   = {in_cell.mom_z, in_cell.mom_y, in_cell.mom_x};
    for (int k = 0; k < 3; k++) begin
      prep_abs_c[k] = prep_mom[k][31] ? (32'd0 - prep_mom[k]) : prep_mom[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_PREP]) begin
      prep_side.rej    <= in_rej;
      prep_side.mom    <= prep_mom;
      prep_side.fld    <= {in_cell.field_z, in_cell.field_y, in_cell.field_x};
      prep_side.energy <= in_cell.energy;
      prep_side.s      <= sat32(50'($signed(prep_neg)));
      prep_abs         <= prep_abs_c;
      // rho is positive whenever the cell is not rejected
      prep_den         <= in_cell.rho[30:0];
    end
  end

  // ---------------------------------------------------------------------------------------
  // velocity magnitudes |mom| * 2^16 / rho
  logic [2:0][QUO_W-1:0] div_quo;
  logic [2:0]            div_ovf;
  side_t                 div_side;

  mpsu_divider u_divider (
    .clk      (clk),
    .en       (en[S_DIV0 +: DIV_STG]),
    .num      (prep_abs),
    .den      (prep_den),
    .side_in  (prep_side),
    .quo      (div_quo),
    .ovf      (div_ovf),
    .side_out (div_side)
  );

  // ---------------------------------------------------------------------------------------
  // stage vel: apply sign, clamp to the signed 32-bit range
  side_t            vel_side;
  logic [2:0][31:0] vel;

  always_ff @(posedge clk) begin
    if (en[S_VEL]) begin
      vel_side <= div_side;
      for (int k = 0; k < 3; k++) begin
        if (div_ovf[k]) begin
          vel[k] <= div_side.mom[k][31] ? 32'h8000_0000 : 32'h7fff_ffff;
        end else if (div_side.mom[k][31]) begin
          vel[k] <= 32'd0 - {1'b0, div_quo[k]};
        end else begin
          vel[k] <= {1'b0, div_quo[k]};
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // stage mul: s*B, s*u and u_k*B_k
  side_t              mul_side;
  logic signed [63:0] mul_sf [3];
  logic signed [63:0] mul_sv [3];
  logic signed [63:0] mul_vf [3];

  always_ff @(posedge clk) begin
    if (en[S_MUL]) begin
      mul_side <= vel_side;
      for (int k = 0; k < 3; k++) begin
        mul_sf[k] <= $signed(vel_side.s) * $signed(vel_side.fld[k]);
        mul_sv[k] <= $signed(vel_side.s) * $signed(vel[k]);
        mul_vf[k] <= $signed(vel[k]) * $signed(vel_side.fld[k]);
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // stage trn: scale products back to q16.16 toward zero
  side_t              trn_side;
  logic signed [47:0] trn_sf [3];
  logic signed [47:0] trn_sv [3];
  logic signed [47:0] trn_vf [3];

  always_ff @(posedge clk) begin
    if (en[S_TRN]) begin
      trn_side <= mul_side;
      for (int k = 0; k < 3; k++) begin
        trn_sf[k] <= trunc_q16(mul_sf[k]);
        trn_sv[k] <= trunc_q16(mul_sv[k]);
        trn_vf[k] <= trunc_q16(mul_vf[k]);
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // stage sum: saturating updates of momentum and field, u.B summed exactly then clamped
  logic [2:0][31:0]   sum_qm;
  logic [2:0][31:0]   sum_qf;
  logic signed [32:0] sum_m [3];
  logic signed [32:0] sum_f [3];
  logic signed [49:0] sum_ub;

  logic               sum_rej;
  logic [2:0][31:0]   sum_nmom;
  logic [2:0][31:0]   sum_nfld;
  logic [31:0]        sum_udotb;
  logic [31:0]        sum_energy;
  logic [31:0]        sum_s;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_qm[k] = sat32(50'(trn_sf[k]));
      sum_qf[k] = sat32(50'(trn_sv[k]));
      sum_m[k]  = $signed({trn_side.mom[k][31], trn_side.mom[k]}) +
                  $signed({sum_qm[k][31], sum_qm[k]});
      sum_f[k]  = $signed({trn_side.fld[k][31], trn_side.fld[k]}) +
                  $signed({sum_qf[k][31], sum_qf[k]});
    end
    sum_ub = 50'(trn_vf[0]) + 50'(trn_vf[1]) + 50'(trn_vf[2]);
  end

  always_ff @(posedge clk) begin
    if (en[S_SUM]) begin
      sum_rej    <= trn_side.rej;
      sum_energy <= trn_side.energy;
      sum_s      <= trn_side.s;
      sum_udotb  <= sat32(sum_ub);
      for (int k = 0; k < 3; k++) begin
        // rejected cells keep their input values
        sum_nmom[k] <= trn_side.rej ? trn_side.mom[k] : sat32(50'(sum_m[k]));
        sum_nfld[k] <= trn_side.rej ? trn_side.fld[k] : sat32(50'(sum_f[k]));
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // stage emul: s * (u.B)
  logic               emul_rej;
  logic [2:0][31:0]   emul_nmom;
  logic [2:0][31:0]   emul_nfld;
  logic [31:0]        emul_energy;
  logic signed [63:0] emul_prod;

  always_ff @(posedge clk) begin
    if (en[S_EMUL]) begin
      emul_rej    <= sum_rej;
      emul_nmom   <= sum_nmom;
      emul_nfld   <= sum_nfld;
      emul_energy <= sum_energy;
      emul_prod   <= $signed(sum_s) * $signed(sum_udotb);
    end
  end

  // ---------------------------------------------------------------------------------------
  // stage etrn
  logic               etrn_rej;
  logic [2:0][31:0]   etrn_nmom;
  logic [2:0][31:0]   etrn_nfld;
  logic [31:0]        etrn_energy;
  logic signed [47:0] etrn_q;

  always_ff @(posedge clk) begin
    if (en[S_ETRN]) begin
      etrn_rej    <= emul_rej;
      etrn_nmom   <= emul_nmom;
      etrn_nfld   <= emul_nfld;
      etrn_energy <= emul_energy;
      etrn_q      <= trunc_q16(emul_prod);
    end
  end

  // ---------------------------------------------------------------------------------------
  // stage out: energy update and result register
  logic [31:0]        out_qe;
  logic signed [32:0] out_e;

  always_comb begin
    out_qe = sat32(50'(etrn_q));
    out_e  = $signed({etrn_energy[31], etrn_energy}) + $signed({out_qe[31], out_qe});
  end

  always_ff @(posedge clk) begin
    if (en[S_OUT]) begin
      result.new_mom_x     <= etrn_nmom[0];
      result.new_mom_y     <= etrn_nmom[1];
      result.new_mom_z     <= etrn_nmom[2];
      result.new_field_x   <= etrn_nfld[0];
      result.new_field_y   <= etrn_nfld[1];
      result.new_field_z   <= etrn_nfld[2];
      result.new_energy    <= etrn_rej ? etrn_energy : sat32(50'(out_e));
      result.density_error <= etrn_rej;
    end
  end

`ifndef ASSERT_OFF
  // input side only stalls when every stage holds a cell and the output is blocked
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !cell_ready |-> ((&vld) && !result_ready))
    else $error("cell_ready low with a free pipeline stage");

  a_cfg_dt: assert property (@(posedge clk) disable iff (rst)
    cfg_we && (cfg_index == REG_TIME_STEP) |=> time_step == $past(cfg_data))
    else $error("time_step write lost");

  a_cfg_min: assert property (@(posedge clk) disable iff (rst)
    cfg_we && (cfg_index == REG_MIN_DENSITY) |=> min_density == $past(cfg_data))
    else $error("min_density write lost");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire

### tb/sv/powell_update_checker.sv
// checker for the powell source update unit: keeps a copy of the registers and predicts each result
// depends on mpsu_pkg; instantiated beside the unit by tb_mhd_powell_source_update_unit
`default_nettype none

module powell_update_checker import mpsu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cell_valid,
  input  logic        cell_ready,
  input  cell_t       cell_req,
  input  logic        result_valid,
  input  logic        result_ready,
  input  result_t     result,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data,
  output int          outstanding,
  output int          fail_count
);

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  longint  step_dt;
  longint  rho_floor;
  result_t updated_q [$];

  function automatic longint clamp32(input longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  // q16.16 product, truncated toward zero
  function automatic longint qprod(input longint a, input longint b);
    return (a * b) / 64'sd65536;
  endfunction

  function automatic result_t powell_update(input cell_t c, input longint dt,
                                            input longint floor_rho);
    longint  rho, divb, nrg, s, udotb;
    longint  mom [3];
    longint  fld [3];
    longint  vel [3];
    longint  nmom [3];
    longint  nfld [3];
    longint  nnrg;
    result_t r;
    rho    = longint'($signed(c.rho));
    divb   = longint'($signed(c.div_b));
    nrg    = longint'($signed(c.energy));
    mom[0] = longint'($signed(c.mom_x));
    mom[1] = longint'($signed(c.mom_y));
    mom[2] = longint'($signed(c.mom_z));
    fld[0] = longint'($signed(c.field_x));
    fld[1] = longint'($signed(c.field_y));
    fld[2] = longint'($signed(c.field_z));
    if (rho <= floor_rho) begin
      nmom = mom;
      nfld = fld;
      nnrg = nrg;
      r.density_error = 1'b1;
    end else begin
      for (int k = 0; k < 3; k++) vel[k] = clamp32((mom[k] * 64'sd65536) / rho);
      s = clamp32(-qprod(dt, divb));
      udotb = clamp32(qprod(vel[0], fld[0]) + qprod(vel[1], fld[1]) + qprod(vel[2], fld[2]));
      for (int k = 0; k < 3; k++) begin
        nmom[k] = clamp32(mom[k] + clamp32(qprod(s, fld[k])));
        nfld[k] = clamp32(fld[k] + clamp32(qprod(s, vel[k])));
      end
      nnrg = clamp32(nrg + clamp32(qprod(s, udotb)));
      r.density_error = 1'b0;
    end
    r.new_mom_x   = nmom[0][31:0];
    r.new_mom_y   = nmom[1][31:0];
    r.new_mom_z   = nmom[2][31:0];
    r.new_field_x = nfld[0][31:0];
    r.new_field_y = nfld[1][31:0];
    r.new_field_z = nfld[2][31:0];
    r.new_energy  = nnrg[31:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count = fail_count + 1;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      step_dt   = longint'(TIME_STEP_RST);
      rho_floor = longint'(MIN_DENSITY_RST);
      updated_q.delete();
      fail_count = 0;
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TIME_STEP:   step_dt = longint'(cfg_data);
          REG_MIN_DENSITY: rho_floor = longint'(cfg_data);
          default: ;
        endcase
      end
      // compare before pushing, so a stray result cannot match a cell taken this cycle
      if (result_valid && result_ready) begin
        if (updated_q.size() == 0) begin
          $error("result with no request pending: %h", result);
          fail_count = fail_count + 1;
        end else begin
          want = updated_q.pop_front();
          check_field("new_mom_x", want.new_mom_x, result.new_mom_x);
          check_field("new_mom_y", want.new_mom_y, result.new_mom_y);
          check_field("new_mom_z", want.new_mom_z, result.new_mom_z);
          check_field("new_field_x", want.new_field_x, result.new_field_x);
          check_field("new_field_y", want.new_field_y, result.new_field_y);
          check_field("new_field_z", want.new_field_z, result.new_field_z);
          check_field("new_energy", want.new_energy, result.new_energy);
          check_field("density_error", {31'd0, want.density_error},
                      {31'd0, result.density_error});
        end
      end
      if (cell_valid && cell_ready) begin
        updated_q.push_back(powell_update(cell_req, step_dt, rho_floor));
      end
      outstanding <= updated_q.size();
    end
  end

endmodule

`default_nettype wire

### tb/sv/tb_mhd_powell_source_update_unit.sv
// testbench top for mhd_powell_source_update_unit: clock, reset, request and config stimulus
// depends on mpsu_pkg, the unit and powell_update_checker, which predicts and counts failures
`default_nettype none

module tb_mhd_powell_source_update_unit import mpsu_pkg::*;;

  // unused register indexes, writes there must be ignored
  localparam logic [1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [1:0] REG_UNUSED_3 = 2'd3;
  // 41-stage pipeline, plus margin
  localparam int DRAIN_CYCLES = 60;
  // worst case is far below this: ~500 requests with long send gaps and long result stalls
  localparam int CYCLE_LIMIT  = 500000;
  localparam int PHASE_ITEMS  = 84;

  logic        clk;
  logic        rst;
  logic        cell_valid;
  logic        cell_ready;
  cell_t       cell_req;
  logic        result_valid;
  logic        result_ready;
  result_t     result_rsp;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [30:0] cfg_data;
  int          outstanding;
  int          fail_count;

  // local copy of min_density, used to aim rho around the rejection threshold
  logic [30:0] rho_min_now;
  // when set the sender streams back to back
  bit          steady;

  // ports in declaration order
  mhd_powell_source_update_unit dut (
    clk, rst, cell_valid, cell_ready, cell_req,
    result_valid, result_ready, result_rsp,
    cfg_we, cfg_index, cfg_data
  );

  powell_update_checker u_check (
    .clk(clk), .rst(rst),
    .cell_valid(cell_valid), .cell_ready(cell_ready), .cell_req(cell_req),
    .result_valid(result_valid), .result_ready(result_ready), .result(result_rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .outstanding(outstanding), .fail_count(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // q16.16 value spread over magnitudes, with the extremes mixed in
  function automatic logic [31:0] rand_q();
    int          sel;
    logic [31:0] v;
    sel = $urandom_range(0, 9);
    v = $urandom;
    if (sel < 4) v = $signed(v) >>> $urandom_range(8, 24);
    else if (sel == 4) v = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
    else if (sel == 5) v = $signed(v) >>> $urandom_range(24, 31);
    return v;
  endfunction

  // density: mostly above the threshold, some right at it, some anything at all
  function automatic logic [31:0] rand_rho();
    int     sel;
    longint r;
    sel = $urandom_range(0, 19);
    if (sel < 2) return $urandom;
    if (sel < 4) begin
      r = longint'(rho_min_now) + longint'($urandom_range(0, 2)) - 1;
      return r[31:0];
    end
    r = longint'(rho_min_now) + 1 + longint'($urandom >> $urandom_range(4, 31));
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    return r[31:0];
  endfunction

  function automatic cell_t rand_cell();
    cell_t c;
    c.rho     = rand_rho();
    c.mom_x   = rand_q();
    c.mom_y   = rand_q();
    c.mom_z   = rand_q();
    c.field_x = rand_q();
    c.field_y = rand_q();
    c.field_z = rand_q();
    c.energy  = rand_q();
    c.div_b   = rand_q();
    return c;
  endfunction

  function automatic cell_t make_cell(input logic [31:0] rho, mx, my, mz, bx, by, bz, e, d);
    cell_t c;
    c.rho     = rho;
    c.mom_x   = mx;
    c.mom_y   = my;
    c.mom_z   = mz;
    c.field_x = bx;
    c.field_y = by;
    c.field_z = bz;
    c.energy  = e;
    c.div_b   = d;
    return c;
  endfunction

  // one request; valid stays up across back-to-back requests
  task automatic send_cell(input cell_t c);
    int gap;
    cell_req   <= c;
    cell_valid <= 1'b1;
    @(posedge clk);
    while (!cell_ready) @(posedge clk);
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      cell_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and wait until every expected result is back
  task automatic drain();
    cell_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // register write, only while the pipeline is empty
  task automatic write_reg(input logic [1:0] idx, input logic [30:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_MIN_DENSITY) rho_min_now = data;
  endtask

  function automatic logic [30:0] rand_dt();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return 31'($urandom_range(0, 32'h0002_0000));
    if (sel < 8) return 31'($urandom >> 1);
    return sel == 8 ? 31'd0 : 31'h7fff_ffff;
  endfunction

  // result side: ready runs of random length broken by stalls, now and then a long clean run
  initial begin
    int n;
    result_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      result_ready <= 1'b1;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
      repeat (n) @(posedge clk);
      n = idle_len();
      if (n > 0) begin
        result_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  // run limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst         <= 1'b1;
    cell_valid  <= 1'b0;
    cell_req    <= '0;
    cfg_we      <= 1'b0;
    cfg_index   <= REG_TIME_STEP;
    cfg_data    <= '0;
    rho_min_now = MIN_DENSITY_RST;
    steady      = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset registers: dt = 66, min density = 1
    // density at, below and far below the threshold passes through flagged
    send_cell(make_cell(32'h1, 32'h0001_2345, 32'hfffe_0000, 32'h7fff_ffff, 32'h8000_0000,
                        32'h0000_8000, 32'hffff_ffff, 32'h0123_4567, 32'h0001_0000));
    send_cell(make_cell(32'h0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000,
                        32'h0005_0000, 32'h0006_0000, 32'h0007_0000, 32'h7fff_ffff));
    send_cell(make_cell(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                        32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    send_cell(make_cell(32'hffff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    // just above the threshold: the largest momentum drives its velocity into saturation
    send_cell(make_cell(32'h2, 32'h1, 32'hffff_ffff, 32'h7fff_ffff, 32'h0001_0000,
                        32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0001_0000));
    // zero divergence leaves the cell as it was
    send_cell(make_cell(32'h0001_0000, 32'h0002_0000, 32'hfffd_0000, 32'h0, 32'h0001_0000,
                        32'h0002_0000, 32'hffff_0000, 32'h0005_0000, 32'h0));
    send_cell(make_cell(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h7fff_ffff,
                        32'h8000_0000, 32'h1, 32'h7fff_ffff, 32'h8000_0000));
    // sums saturating high, then low
    send_cell(make_cell(32'h0001_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                        32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000));
    send_cell(make_cell(32'h0001_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    send_cell(make_cell(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
    send_cell(make_cell(32'h3, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                        32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
    drain();

    // largest time step, nothing rejected but zero and negative density
    write_reg(REG_TIME_STEP, 31'h7fff_ffff);
    write_reg(REG_MIN_DENSITY, 31'd0);
    send_cell(make_cell(32'h1, 32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000, 32'h0001_0000,
                        32'hffff_0000, 32'h0000_0001, 32'h0, 32'h0001_0000));
    send_cell(make_cell(32'h1, 32'h0000_0100, 32'hffff_ff00, 32'h0, 32'h0000_0010,
                        32'h0000_0010, 32'h0000_0010, 32'h0001_0000, 32'h7fff_ffff));
    send_cell(make_cell(32'h1, 32'h0000_0100, 32'hffff_ff00, 32'h0, 32'h0000_0010,
                        32'hffff_fff0, 32'h0000_0010, 32'hffff_0000, 32'h8000_0000));
    send_cell(make_cell(32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                        32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
    send_cell(make_cell(32'h7fff_ffff, 32'h4000_0000, 32'hc000_0000, 32'h0000_ffff,
                        32'h0000_0001, 32'h0100_0000, 32'hff00_0000, 32'h1234_5678, 32'h0000_0001));
    drain();

    // largest threshold: every density is rejected
    write_reg(REG_MIN_DENSITY, 31'h7fff_ffff);
    send_cell(make_cell(32'h7fff_ffff, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                        32'h0004_0000, 32'h0005_0000, 32'h0006_0000, 32'h0007_0000, 32'h0008_0000));
    send_cell(make_cell(32'h4000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h1,
                        32'hffff_ffff, 32'h0, 32'h8000_0000, 32'h7fff_ffff));
    drain();

    // zero time step, then writes to unused indexes must not touch anything
    write_reg(REG_TIME_STEP, 31'd0);
    write_reg(REG_MIN_DENSITY, 31'd0);
    write_reg(REG_UNUSED_2, 31'h7fff_ffff);
    write_reg(REG_UNUSED_3, 31'h5555_5555);
    send_cell(make_cell(32'h0002_0000, 32'h0003_0000, 32'hfffd_0000, 32'h0000_8000,
                        32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'h7fff_ffff));
    send_cell(make_cell(32'h0000_8000, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000,
                        32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h7fff_ffff, 32'h8000_0000));
    drain();

    // random phases, each under its own register setting
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(REG_TIME_STEP, rand_dt());
      if (phase == 1) write_reg(REG_MIN_DENSITY, 31'd0);
      else if ($urandom_range(0, 3) == 0) write_reg(REG_MIN_DENSITY, 31'($urandom >> 1));
      else write_reg(REG_MIN_DENSITY, 31'($urandom_range(0, 32'h0004_0000)));
      if (phase == 3) write_reg($urandom_range(0, 1) ? REG_UNUSED_2 : REG_UNUSED_3, 31'($urandom));
      steady = (phase == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_cell(rand_cell());
        // hold off mid-phase until the pipeline has emptied
        if (i == PHASE_ITEMS / 2 && phase == 4) drain();
      end
      steady = 1'b0;
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

### mhd_powell_source_update_unit.f
rtl/mpsu_pkg.sv
rtl/mpsu_divider.sv
rtl/mhd_powell_source_update_unit.sv
tb/sv/powell_update_checker.sv
tb/sv/tb_mhd_powell_source_update_unit.sv
